// File: hdl/ds2i_pkg.sv
// ds2i_pkg: parse phase type, character codes and limits for the decimal
// string parser. No dependencies.
`default_nettype none

package ds2i_pkg;

    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_SIGN  = 3'd1,
        PH_DIGIT = 3'd2,
        PH_TRAIL = 3'd3,
        PH_ERR   = 3'd4
    } phase_t;

    localparam logic [7:0]  CHAR_NUL   = 8'h00;
    localparam logic [7:0]  CHAR_TAB   = 8'h09;
    localparam logic [7:0]  CHAR_CR    = 8'h0D;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;
    localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
    localparam logic [7:0]  CHAR_MINUS = 8'h2D;
    localparam logic [7:0]  CHAR_ZERO  = 8'h30;
    localparam logic [7:0]  CHAR_NINE  = 8'h39;

    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

    // space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

`default_nettype wire

// File: hdl/decimal_string_to_int64_core.sv
// decimal_string_to_int64_core: streaming decimal string to 64-bit integer
// parser with overflow check. Depends on ds2i_pkg.
//
// Path: an accepted item is first held in the input register; a terminator's
// result is then loaded into the result register, but waits while an untaken
// result holds the result register (the terminator then waits and the input stalls).
// Throughput: one item per cycle while results are taken; the 64-bit
// times-ten-plus-digit update and its limit compare form the state loop.
// Reset (rst_n low, async): parser back in the leading whitespace phase,
// accumulator zero, unsigned mode, both pipeline registers empty.
`default_nettype none

module decimal_string_to_int64_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: signed_mode
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    // input items
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  char_byte,
    // result items
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      value,
    output logic             parse_error
);
    import ds2i_pkg::*;

    // config register
    logic        signed_mode_reg;

    // input register stage
    logic        s1_valid_reg;
    logic [7:0]  s1_char_reg;

    // parse state
    phase_t      phase_reg, phase_next;
    logic [63:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;

    // result register
    logic        out_valid_reg;
    logic [63:0] value_reg, value_next;
    logic        err_reg, err_next;

    // handshake helpers
    logic        s1_is_term;
    logic        out_free;
    logic        s1_fire;

    // digit step
    logic [3:0]  digit;
    logic [63:0] lim;
    logic [67:0] prod;
    logic        ovf;
    logic        ch_ws;
    logic        ch_dig;
    logic        ch_sign;
    logic        result_ok;

    // Config writes are always taken; the user must send them only while the block is idle (not enforced here).
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            signed_mode_reg <= cfg_data;
        end
    end

    // Only the terminator needs room in the result register; other items
    // pass straight through the state update.
    assign s1_is_term = (s1_char_reg == CHAR_NUL);
    assign out_free   = !out_valid_reg || out_ready;
    assign s1_fire    = s1_valid_reg && (!s1_is_term || out_free);
    assign in_ready   = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_char_reg <= char_byte;
        end
    end

    // Character class and the digit step. acc*10 + d is built as two shifts
    // and two adds in 68 bits; it overflows when it exceeds the active limit.
    assign ch_ws   = is_ws(s1_char_reg);
    assign ch_dig  = is_dig(s1_char_reg);
    assign ch_sign = signed_mode_reg &&
                     ((s1_char_reg == CHAR_PLUS) || (s1_char_reg == CHAR_MINUS));
    assign digit   = s1_char_reg[3:0];

    always_comb
    begin
        if (signed_mode_reg)
        begin
            lim = neg_reg ? NEG_LIMIT : POS_LIMIT;
        end
        else
        begin
            lim = ALL_ONES;
        end
    end

    assign prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {64'd0, digit};
    assign ovf  = (prod > {4'd0, lim});

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (s1_is_term)
        begin
            phase_next = PH_LEAD;
        end
        else
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    if (ch_ws)
                        phase_next = PH_LEAD;
                    else if (ch_sign)
                        phase_next = PH_SIGN;
                    else if (ch_dig)
                        phase_next = ovf ? PH_ERR : PH_DIGIT;
                    else
                        phase_next = PH_ERR;
                end
                PH_SIGN:
                begin
                    if (ch_dig)
                        phase_next = ovf ? PH_ERR : PH_DIGIT;
                    else
                        phase_next = PH_ERR;
                end
                PH_DIGIT:
                begin
                    if (ch_dig)
                        phase_next = ovf ? PH_ERR : PH_DIGIT;
                    else if (ch_ws)
                        phase_next = PH_TRAIL;
                    else
                        phase_next = PH_ERR;
                end
                PH_TRAIL:
                begin
                    phase_next = ch_ws ? PH_TRAIL : PH_ERR;
                end
                default:
                begin
                    phase_next = PH_ERR;
                end
            endcase
        end
    end

    // accumulator, sign flag and result
    always_comb
    begin
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        result_ok  = (phase_reg == PH_DIGIT) || (phase_reg == PH_TRAIL);
        value_next = 64'd0;
        err_next   = !result_ok;
        if (s1_is_term)
        begin
            acc_next = 64'd0;
            neg_next = 1'b0;
            if (result_ok)
            begin
                value_next = neg_reg ? (64'd0 - acc_reg) : acc_reg;
            end
        end
        else
        begin
            case (phase_reg)
                PH_LEAD:
                begin
                    if (!ch_ws && ch_sign)
                        neg_next = (s1_char_reg == CHAR_MINUS);
                    else if (!ch_ws && ch_dig && !ovf)
                        acc_next = prod[63:0];
                end
                PH_SIGN, PH_DIGIT:
                begin
                    if (ch_dig && !ovf)
                        acc_next = prod[63:0];
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            acc_reg   <= 64'd0;
            neg_reg   <= 1'b0;
        end
        else if (s1_fire)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
        end
    end

    // result register: loaded by the terminator, held until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_is_term)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_is_term)
        begin
            value_reg <= value_next;
            err_reg   <= err_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign parse_error = err_reg;

    // A terminator returns the parser to its reset state.
    a_term_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_is_term) |=> (phase_reg == PH_LEAD) && (acc_reg == 64'd0) && !neg_reg)
        else $error("parser state not cleared after terminator");

    // Input stalls only behind a terminator that waits for the result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_is_term && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked terminator");

    // No digit has been taken while still in the leading whitespace phase.
    a_lead_acc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEAD) |-> (acc_reg == 64'd0))
        else $error("accumulator nonzero in leading phase");

endmodule

`default_nettype wire
